FILE: design/inetcs_pkg.sv
// ----------------------------------------------------------------------------
// Internet checksum package
// Shared widths and types for the 64-bit ones'-complement checksum core.
// ----------------------------------------------------------------------------
package inetcs_pkg;

  localparam int WORD_W  = 64;
  localparam int COUNT_W = 4;
  localparam int CSUM_W  = 16;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [CSUM_W-1:0]  csum_t;

endpackage

FILE: design/inetcs_operand.sv
// ----------------------------------------------------------------------------
// Internet checksum addend selection
// Turns one data word and its byte count into the single value that is added
// to the running sum: the whole word, or the sum of the short-word pieces.
// ----------------------------------------------------------------------------
module inetcs_operand (
  input  inetcs_pkg::word_t  data_word,
  input  inetcs_pkg::count_t byte_count,
  output inetcs_pkg::word_t  operand
);
  import inetcs_pkg::*;

  logic        full_word;
  logic [31:0] piece32;
  logic [31:0] after32;
  logic [15:0] piece16;
  logic [15:0] after16;
  logic [7:0]  piece8;
  logic [32:0] piece_sum;

  // The pieces are small, so at most one end-around carry can occur and
  // adding their sum once gives the same result as adding them in turn.
  always_comb begin
    full_word = byte_count[3];
    piece32   = byte_count[2] ? data_word[31:0] : 32'd0;
    after32   = byte_count[2] ? data_word[63:32] : data_word[31:0];
    piece16   = byte_count[1] ? after32[15:0] : 16'd0;
    after16   = byte_count[1] ? after32[31:16] : after32[15:0];
    piece8    = byte_count[0] ? after16[7:0] : 8'd0;
    piece_sum = {1'b0, piece32} + {17'd0, piece16} + {25'd0, piece8};
    operand   = full_word ? data_word : {{(WORD_W-33){1'b0}}, piece_sum};
  end

endmodule

FILE: design/inetcs_fold.sv
// ----------------------------------------------------------------------------
// Internet checksum fold
// Folds a 64-bit ones'-complement sum to 16 bits with end-around carries and
// inverts it.
// ----------------------------------------------------------------------------
module inetcs_fold (
  input  inetcs_pkg::word_t sum,
  output inetcs_pkg::csum_t checksum
);
  import inetcs_pkg::*;

  logic [32:0] half_sum;
  logic [31:0] fold32;
  logic [16:0] quarter_sum;
  logic [15:0] fold16;

  always_comb begin
    half_sum    = {1'b0, sum[31:0]} + {1'b0, sum[63:32]};
    fold32      = half_sum[31:0] + {31'd0, half_sum[32]};
    quarter_sum = {1'b0, fold32[15:0]} + {1'b0, fold32[31:16]};
    fold16      = quarter_sum[15:0] + {15'd0, quarter_sum[16]};
    checksum    = ~fold16;
  end

endmodule

FILE: design/internet_checksum_64bit_core.sv
// ----------------------------------------------------------------------------
// Internet checksum core, 64 bits per request
// Keeps a 64-bit ones'-complement running sum over little-endian words and
// returns the folded, inverted 16-bit checksum on the last word.
// ----------------------------------------------------------------------------
//  Channel   Handshake                   Payload
//  item      item_valid / item_ready     data_word, byte_count, first,
//                                        seed_sum, last
//  result    result_valid / result_ready running_sum, checksum_value, is_last
//
//  One request per cycle is accepted while item_ready is high; each result
//  passes through three registers: input, sum and fold register.
//  The running sum is updated as a request leaves the input register, so the
//  next request sees it in the following cycle with no gap.
//  Reset clears the running sum and all stage valid flags.
//  A stalled result holds the output stage while stages behind it fill gaps;
//  item_ready drops only when all stages are full and result_ready is low.
// ----------------------------------------------------------------------------
module internet_checksum_64bit_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  inetcs_pkg::word_t  data_word,
  input  inetcs_pkg::count_t byte_count,
  input  logic               first,
  input  inetcs_pkg::word_t  seed_sum,
  input  logic               last,
  output logic               result_valid,
  input  logic               result_ready,
  output inetcs_pkg::word_t  running_sum,
  output inetcs_pkg::csum_t  checksum_value,
  output logic               is_last
);
  import inetcs_pkg::*;

  word_t operand_in;
  word_t checksum_fold_in;
  csum_t checksum_fold;

  logic  in_full;
  word_t in_operand;
  logic  in_first;
  word_t in_seed;
  logic  in_last;

  logic  sum_full;
  word_t sum_value;
  logic  sum_last;

  word_t acc;
  word_t base;
  logic [WORD_W:0] raw_sum;
  word_t acc_next;

  logic  out_full;
  word_t out_sum;
  csum_t out_csum;
  logic  out_last;

  logic out_free;
  logic sum_free;
  logic in_free;
  logic in_move;
  logic sum_move;

  inetcs_operand u_operand (
    .data_word (data_word),
    .byte_count(byte_count),
    .operand   (operand_in)
  );

  assign out_free   = !out_full || result_ready;
  assign sum_free   = !sum_full || out_free;
  assign in_free    = !in_full || sum_free;
  assign in_move    = in_full && sum_free;
  assign sum_move   = sum_full && out_free;
  assign item_ready = in_free;

  always_comb begin
    base     = in_first ? in_seed : acc;
    raw_sum  = {1'b0, base} + {1'b0, in_operand};
    acc_next = raw_sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, raw_sum[WORD_W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      sum_full <= 1'b0;
      out_full <= 1'b0;
      acc      <= '0;
    end else begin
      if (in_free) begin
        in_full <= item_valid;
      end
      if (sum_free) begin
        sum_full <= in_full;
      end
      if (out_free) begin
        out_full <= sum_full;
      end
      if (in_move) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && item_valid) begin
      in_operand <= operand_in;
      in_first   <= first;
      in_seed    <= seed_sum;
      in_last    <= last;
    end
    if (in_move) begin
      sum_value <= acc_next;
      sum_last  <= in_last;
    end
    if (sum_move) begin
      out_sum  <= sum_value;
      out_csum <= sum_last ? checksum_fold : '0;
      out_last <= sum_last;
    end
  end

  assign checksum_fold_in = sum_value;

  inetcs_fold u_fold (
    .sum     (checksum_fold_in),
    .checksum(checksum_fold)
  );

  assign result_valid   = out_full;
  assign running_sum    = out_sum;
  assign checksum_value = out_csum;
  assign is_last        = out_last;

endmodule

FILE: design/inetcs_checker.sv
// ----------------------------------------------------------------------------
// Internet checksum checker
// Port-level assertions for the checksum core, attached by a bind statement.
// ----------------------------------------------------------------------------
module inetcs_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_ready,
  input logic               result_valid,
  input logic               result_ready,
  input inetcs_pkg::word_t  running_sum,
  input inetcs_pkg::csum_t  checksum_value,
  input logic               is_last
);
  import inetcs_pkg::*;

  function automatic csum_t fold_sum(word_t s);
    logic [32:0] h;
    logic [31:0] f32;
    logic [16:0] q;
    logic [15:0] f16;
    h   = {1'b0, s[31:0]} + {1'b0, s[63:32]};
    f32 = h[31:0] + {31'd0, h[32]};
    q   = {1'b0, f32[15:0]} + {1'b0, f32[31:16]};
    f16 = q[15:0] + {15'd0, q[16]};
    return ~f16;
  endfunction

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(running_sum)
      && $stable(checksum_value) && $stable(is_last))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_mid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_last |-> checksum_value == '0)
    else $error("checksum nonzero on a result that is not last");

  a_close: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_last |-> checksum_value == fold_sum(running_sum))
    else $error("checksum does not match the folded running sum");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("request refused while the pipeline drains freely");

endmodule

bind internet_checksum_64bit_core inetcs_checker u_inetcs_checker (.*);
